// ===== design/tlik_pkg.sv =====
// shared types, constants and the arctangent table for the two-link leg solver
// no dependencies
package tlik_pkg;

  localparam logic [0:0] CFG_UPPER = 1'b0;
  localparam logic [0:0] CFG_LOWER = 1'b1;

  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [28:0] ROUND_HALF  = 29'sd2048;
  localparam logic signed [21:0] HALF_TURN_M1 = 22'sd12867;
  localparam logic [14:0]        TURN_Q12    = 15'd25736;
  localparam logic signed [21:0] TURN_BIAS   = 22'sd283096;
  localparam logic [17:0]        TURN_RECIP  = 18'd166885;
  localparam logic signed [20:0] ANG_MAX     = 21'sd262143;
  localparam logic signed [20:0] ANG_MIN     = -21'sd262144;

  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned SQRT_STEPS   = 28;

  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [18:0] r1;
    logic signed [18:0] r2;
  } item_t;

  typedef struct packed {
    logic signed [13:0] x;
    logic signed [13:0] y;
    logic signed [29:0] num;
    logic               bad;
    logic signed [18:0] r1;
    logic signed [18:0] r2;
  } geo_t;

  typedef struct packed {
    logic               bad;
    logic signed [18:0] r1;
    logic signed [18:0] r2;
  } side_t;

  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
  } quad_t;

  function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
    logic signed [27:0] v;
    case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = 28'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/tlik_isqrt.sv =====
// pipelined floor square root, one result bit per stage, 28 stages
// depends on tlik_pkg
module tlik_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [55:0] rad_i,
  output logic [27:0] root_o
);

  logic [56:0] v_r   [0:tlik_pkg::SQRT_STEPS];
  logic [56:0] res_r [0:tlik_pkg::SQRT_STEPS];

  assign v_r[0]   = {1'b0, rad_i};
  assign res_r[0] = '0;

  for (genvar g = 0; g < tlik_pkg::SQRT_STEPS; g++) begin : g_step
    localparam logic [56:0] BIT = 57'(1) << (54 - 2 * g);
    logic [56:0] rb;
    assign rb = res_r[g] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_r[g] >= rb) begin
          v_r[g+1]   <= v_r[g] - rb;
          res_r[g+1] <= (res_r[g] >> 1) + BIT;
        end else begin
          v_r[g+1]   <= v_r[g];
          res_r[g+1] <= res_r[g] >> 1;
        end
      end
    end
  end

  assign root_o = res_r[tlik_pkg::SQRT_STEPS][27:0];

endmodule

// ===== design/tlik_atan2.sv =====
// pipelined atan2 in 2^-24 rad: fold, normalise, 24 cordic vectoring stages, unfold
// depends on tlik_pkg
module tlik_atan2 (
  input  logic               clk,
  input  logic               en,
  input  logic signed [29:0] y_i,
  input  logic signed [29:0] x_i,
  output logic signed [27:0] ang_o
);

  logic [29:0]          ax_r, ay_r, ax1_r, ay1_r;
  tlik_pkg::quad_t      q0_r, q1_r;
  logic [4:0]           sh_r, sh_nxt;
  logic [29:0]          mx;
  logic signed [33:0]   cx_r [0:tlik_pkg::CORDIC_STEPS];
  logic signed [33:0]   cy_r [0:tlik_pkg::CORDIC_STEPS];
  logic signed [27:0]   z_r  [0:tlik_pkg::CORDIC_STEPS];
  tlik_pkg::quad_t      q_r  [0:tlik_pkg::CORDIC_STEPS];
  logic signed [27:0]   ang_r, fold, ang_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r      <= x_i[29] ? 30'(-x_i) : 30'(x_i);
      ay_r      <= y_i[29] ? 30'(-y_i) : 30'(y_i);
      q0_r.xneg <= x_i[29];
      q0_r.yneg <= y_i[29];
      q0_r.zero <= (x_i == '0) && (y_i == '0);
    end
  end

  // leading zero count of the larger magnitude
  always_comb begin
    mx     = (ax_r > ay_r) ? ax_r : ay_r;
    sh_nxt = '0;
    for (int i = 0; i < 30; i++) begin
      if (mx[i]) sh_nxt = 5'(29 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= ax_r;
      ay1_r <= ay_r;
      sh_r  <= sh_nxt;
      q1_r  <= q0_r;
      cx_r[0] <= $signed({4'b0, 30'(ax1_r << sh_r)});
      cy_r[0] <= $signed({4'b0, 30'(ay1_r << sh_r)});
      z_r[0]  <= '0;
      q_r[0]  <= q1_r;
    end
  end

  for (genvar g = 0; g < tlik_pkg::CORDIC_STEPS; g++) begin : g_rot
    logic signed [33:0] dx, dy;
    logic signed [27:0] tab;
    assign dx  = cy_r[g] >>> g;
    assign dy  = cx_r[g] >>> g;
    assign tab = tlik_pkg::atan_q24(5'(g));
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[g+1] <= q_r[g];
        if (!cy_r[g][33]) begin
          cx_r[g+1] <= cx_r[g] + dx;
          cy_r[g+1] <= cy_r[g] - dy;
          z_r[g+1]  <= z_r[g] + tab;
        end else begin
          cx_r[g+1] <= cx_r[g] - dx;
          cy_r[g+1] <= cy_r[g] + dy;
          z_r[g+1]  <= z_r[g] - tab;
        end
      end
    end
  end

  always_comb begin
    fold    = q_r[tlik_pkg::CORDIC_STEPS].xneg ?
              tlik_pkg::PI_Q24 - z_r[tlik_pkg::CORDIC_STEPS] : z_r[tlik_pkg::CORDIC_STEPS];
    ang_nxt = q_r[tlik_pkg::CORDIC_STEPS].yneg ? -fold : fold;
    if (q_r[tlik_pkg::CORDIC_STEPS].zero) ang_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (en) ang_r <= ang_nxt;
  end

  assign ang_o = ang_r;

endmodule

// ===== design/two_link_leg_inverse_kinematics.sv =====
// top level of the two-link leg solver: geometry, square root, two atan2 pipelines, unwrap
// depends on tlik_pkg, tlik_isqrt, tlik_atan2
//
// channel  direction  tdata                                        tuser
// in_      slave      x[13:0] y[27:14] prev1[46:28] prev2[65:47]   -
// out_     master     angle_one[18:0] angle_two[37:19]             reachable[0]
// cfg_     write      index 0 upper link, 1 lower link, 13 bit     -
//
// one transfer per cycle sustained while out_tready stays high
// the pipeline length is set mostly by the 28 square-root stages and the 28 atan2 stages
// all stages advance together; a waiting result freezes the pipeline
// a one-entry input skid register keeps in_tready a plain register output
// rst_n clears valid bits and the skid; link lengths reset to 1512 and 1800
module two_link_leg_inverse_kinematics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // target_x, target_y, prev_angle_one, prev_angle_two, zeros
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // angle_one, angle_two, zeros
  output logic [0:0]  out_tuser   // reachable
);

  localparam int unsigned NSTG = 67;
  localparam int unsigned DLY  = 28;

  logic [12:0] l1_r, l2_r;
  logic [NSTG-1:0] vld_r;
  logic en;
  logic skid_v_r;
  tlik_pkg::item_t skid_r, in_item, src;
  logic src_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= 13'd1512;
      l2_r <= 13'd1800;
    end else if (cfg_we) begin
      case (cfg_index)
        tlik_pkg::CFG_UPPER: l1_r <= cfg_wdata;
        tlik_pkg::CFG_LOWER: l2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = !vld_r[NSTG-1] || out_tready;
  assign in_tready = !skid_v_r;
  assign in_item   = '{x: $signed(in_tdata[13:0]), y: $signed(in_tdata[27:14]),
                       r1: $signed(in_tdata[46:28]), r2: $signed(in_tdata[65:47])};
  assign src       = skid_v_r ? skid_r : in_item;
  assign src_v     = skid_v_r || in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      if (en) begin
        skid_v_r <= 1'b0;
        vld_r    <= {vld_r[NSTG-2:0], src_v};
      end else if (in_tvalid && !skid_v_r) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_tvalid && !skid_v_r) skid_r <= in_item;
  end

  // squares
  logic [26:0] p1_xx_r, p1_yy_r;
  logic [25:0] p1_l1sq_r, p1_l2sq_r, p1_dfsq_r;
  logic [27:0] p1_smsq_r;
  logic        p1_zero_r;
  tlik_pkg::item_t p1_it_r;
  logic signed [27:0] xsq, ysq;
  logic [13:0] lsum;
  logic [12:0] ldif;

  assign xsq  = src.x * src.x;
  assign ysq  = src.y * src.y;
  assign lsum = {1'b0, l1_r} + {1'b0, l2_r};
  assign ldif = (l1_r > l2_r) ? l1_r - l2_r : l2_r - l1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_xx_r   <= 27'(xsq);
      p1_yy_r   <= 27'(ysq);
      p1_l1sq_r <= l1_r * l1_r;
      p1_l2sq_r <= l2_r * l2_r;
      p1_smsq_r <= lsum * lsum;
      p1_dfsq_r <= ldif * ldif;
      p1_zero_r <= (src.x == '0) && (src.y == '0);
      p1_it_r   <= src;
    end
  end

  // distance squared
  logic [27:0] p2_lsq_r, p2_smsq_r;
  logic [25:0] p2_l1sq_r, p2_dfsq_r;
  logic signed [26:0] p2_d12_r;
  logic p2_zero_r;
  tlik_pkg::item_t p2_it_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_lsq_r  <= {1'b0, p1_xx_r} + {1'b0, p1_yy_r};
      p2_d12_r  <= $signed({1'b0, p1_l1sq_r}) - $signed({1'b0, p1_l2sq_r});
      p2_smsq_r <= p1_smsq_r;
      p2_l1sq_r <= p1_l1sq_r;
      p2_dfsq_r <= p1_dfsq_r;
      p2_zero_r <= p1_zero_r;
      p2_it_r   <= p1_it_r;
    end
  end

  // reach test, cosine numerator, 4 l1^2 L^2 partial
  logic signed [29:0] p3_num_r;
  logic [53:0] p3_p_r;
  logic p3_bad_r;
  tlik_pkg::item_t p3_it_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_bad_r <= p2_zero_r || (p2_lsq_r > p2_smsq_r) || (p2_lsq_r < {2'b0, p2_dfsq_r});
      p3_num_r <= $signed({2'b0, p2_lsq_r}) + {{3{p2_d12_r[26]}}, p2_d12_r};
      p3_p_r   <= p2_l1sq_r * p2_lsq_r;
      p3_it_r  <= p2_it_r;
    end
  end

  logic signed [59:0] nsq_full;
  logic [57:0] p4_nsq_r;
  logic [53:0] p4_p_r;
  logic signed [29:0] p4_num_r;
  logic p4_bad_r;
  tlik_pkg::item_t p4_it_r;

  assign nsq_full = p3_num_r * p3_num_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_nsq_r <= nsq_full[57:0];
      p4_p_r   <= p3_p_r;
      p4_num_r <= p3_num_r;
      p4_bad_r <= p3_bad_r;
      p4_it_r  <= p3_it_r;
    end
  end

  // radicand, clamped at zero
  logic [57:0] p4x4;
  logic [55:0] p5_rad_r;
  tlik_pkg::geo_t p5_geo_r;

  assign p4x4 = {2'b0, p4_p_r, 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      p5_rad_r     <= (p4_nsq_r > p4x4) ? '0 : 56'(p4x4 - p4_nsq_r);
      p5_geo_r.x   <= p4_it_r.x;
      p5_geo_r.y   <= p4_it_r.y;
      p5_geo_r.num <= p4_num_r;
      p5_geo_r.bad <= p4_bad_r;
      p5_geo_r.r1  <= p4_it_r.r1;
      p5_geo_r.r2  <= p4_it_r.r2;
    end
  end

  logic [27:0] root;

  tlik_isqrt u_isqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (p5_rad_r),
    .root_o (root)
  );

  tlik_pkg::geo_t  d1_r [0:DLY-1];
  tlik_pkg::side_t d2_r [0:DLY-1];
  tlik_pkg::geo_t  g1;

  assign g1 = d1_r[DLY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r[0]     <= p5_geo_r;
      d2_r[0].bad <= g1.bad;
      d2_r[0].r1  <= g1.r1;
      d2_r[0].r2  <= g1.r2;
      for (int i = 1; i < DLY; i++) begin
        d1_r[i] <= d1_r[i-1];
        d2_r[i] <= d2_r[i-1];
      end
    end
  end

  logic signed [27:0] phi, beta;

  tlik_atan2 u_phi (
    .clk   (clk),
    .en    (en),
    .y_i   ({{16{g1.y[13]}}, g1.y}),
    .x_i   ({{16{g1.x[13]}}, g1.x}),
    .ang_o (phi)
  );

  tlik_atan2 u_beta (
    .clk   (clk),
    .en    (en),
    .y_i   ($signed({2'b0, root})),
    .x_i   (g1.num),
    .ang_o (beta)
  );

  // joint angles, rounded to 2^-12 rad
  logic signed [28:0] s1, s2, phi_x, beta_x;
  logic signed [16:0] c1_ang_r [0:1];
  tlik_pkg::side_t c1_sd_r;

  assign phi_x  = {phi[27], phi};
  assign beta_x = {beta[27], beta};
  assign s1 = phi_x - beta_x + tlik_pkg::ROUND_HALF;
  assign s2 = {tlik_pkg::PI_Q24[27], tlik_pkg::PI_Q24} - phi_x - beta_x + tlik_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_ang_r[0] <= s1[28:12];
      c1_ang_r[1] <= s2[28:12];
      c1_sd_r     <= d2_r[DLY-1];
    end
  end

  // unwrap around the previous angle
  logic signed [18:0] refs [0:1];
  logic [19:0] u1_t_r [0:1], u2_t_r [0:1], u3_t_r [0:1];
  logic [37:0] u2_prod_r [0:1];
  logic [20:0] u3_qc_r [0:1];
  logic [14:0] u4_rem_r [0:1];
  logic [18:0] u5_ang_r [0:1];
  tlik_pkg::side_t u1_sd_r, u2_sd_r, u3_sd_r, u4_sd_r;
  logic u5_ok_r;
  logic signed [21:0] tsum [0:1];
  logic [20:0] rem0 [0:1];
  logic signed [20:0] runw [0:1];

  assign refs[0] = c1_sd_r.r1;
  assign refs[1] = c1_sd_r.r2;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      tsum[k] = {{5{c1_ang_r[k][16]}}, c1_ang_r[k]} - {{3{refs[k][18]}}, refs[k]}
                + tlik_pkg::HALF_TURN_M1 + tlik_pkg::TURN_BIAS;
      rem0[k] = {1'b0, u3_t_r[k]} - u3_qc_r[k];
      runw[k] = {{2{(k == 0) ? u4_sd_r.r1[18] : u4_sd_r.r2[18]}},
                 (k == 0) ? u4_sd_r.r1 : u4_sd_r.r2}
                + $signed({6'b0, u4_rem_r[k]}) - 21'(tlik_pkg::HALF_TURN_M1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        u1_t_r[k]    <= tsum[k][19:0];
        u2_t_r[k]    <= u1_t_r[k];
        u2_prod_r[k] <= u1_t_r[k] * tlik_pkg::TURN_RECIP;
        u3_t_r[k]    <= u2_t_r[k];
        u3_qc_r[k]   <= u2_prod_r[k][37:32] * tlik_pkg::TURN_Q12;
        u4_rem_r[k]  <= (rem0[k] >= {6'b0, tlik_pkg::TURN_Q12}) ?
                        15'(rem0[k] - {6'b0, tlik_pkg::TURN_Q12}) : rem0[k][14:0];
        if (u4_sd_r.bad) begin
          u5_ang_r[k] <= (k == 0) ? u4_sd_r.r1 : u4_sd_r.r2;
        end else if (runw[k] > tlik_pkg::ANG_MAX) begin
          u5_ang_r[k] <= tlik_pkg::ANG_MAX[18:0];
        end else if (runw[k] < tlik_pkg::ANG_MIN) begin
          u5_ang_r[k] <= tlik_pkg::ANG_MIN[18:0];
        end else begin
          u5_ang_r[k] <= runw[k][18:0];
        end
      end
      u1_sd_r <= c1_sd_r;
      u2_sd_r <= u1_sd_r;
      u3_sd_r <= u2_sd_r;
      u4_sd_r <= u3_sd_r;
      u5_ok_r <= !u4_sd_r.bad;
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {2'b00, u5_ang_r[1], u5_ang_r[0]};
  assign out_tuser  = u5_ok_r;

`ifndef SYNTHESIS
  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(!en))
    else $error("skid filled while pipeline advanced");

  a_stall_holds_valids: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  a_stalled_input_parked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !en) |=> skid_v_r)
    else $error("input transfer lost during stall");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && en) |=> (vld_r[0] && !skid_v_r))
    else $error("parked item not taken into pipeline");
`endif

endmodule
